// File: rtl/bpf_pkg.sv
package bpf_pkg;

    // Framing constants
    localparam int FRAME_BYTES = 12;
    localparam int MAX_FPP     = 17;
    localparam int OVERHEAD    = 7;
    localparam int MTU_W       = 10;
    localparam int FRAMES_W    = 16;
    localparam int SEQ_W       = 16;
    localparam int CRC_W       = 32;
    localparam int BURST_W     = $clog2(((1 << FRAMES_W) - 1) * FRAME_BYTES + 1);
    localparam int PKT_W       = $clog2(MAX_FPP * FRAME_BYTES + 1);
    // compare width covers the full MTU register range
    localparam int CMP_W       = MTU_W + 1;

    localparam logic [MTU_W-1:0] MTU_RESET = MTU_W'(23);
    localparam logic [CRC_W-1:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [7:0]       TYPE_DATA = 8'h02;
    localparam logic [7:0]       TYPE_END  = 8'h03;

    // Input item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Output step positions within one command
    localparam int IDX_W = 5;
    localparam logic [IDX_W-1:0] ST_HDR_TYPE  = 5'd0;
    localparam logic [IDX_W-1:0] ST_HDR_SEQH  = 5'd1;
    localparam logic [IDX_W-1:0] ST_HDR_SEQL  = 5'd2;
    localparam logic [IDX_W-1:0] ST_HDR_LEN   = 5'd3;
    localparam logic [IDX_W-1:0] ST_DATA      = 5'd4;
    localparam logic [IDX_W-1:0] ST_END_TYPE  = 5'd5;
    localparam logic [IDX_W-1:0] ST_END_SEQH  = 5'd6;
    localparam logic [IDX_W-1:0] ST_END_SEQL  = 5'd7;
    localparam logic [IDX_W-1:0] ST_END_PAD   = 5'd8;
    localparam logic [IDX_W-1:0] ST_END_CNT3  = 5'd9;
    localparam logic [IDX_W-1:0] ST_END_CNT2  = 5'd10;
    localparam logic [IDX_W-1:0] ST_END_CNT1  = 5'd11;
    localparam logic [IDX_W-1:0] ST_END_CNT0  = 5'd12;
    localparam logic [IDX_W-1:0] ST_END_CRC3  = 5'd13;
    localparam logic [IDX_W-1:0] ST_END_CRC2  = 5'd14;
    localparam logic [IDX_W-1:0] ST_END_CRC1  = 5'd15;
    localparam logic [IDX_W-1:0] ST_END_CRC0  = 5'd16;

    typedef struct packed {
        logic                mode;
        logic [FRAMES_W-1:0] frame_total;
        logic [7:0]          data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_last;
    } t_out_item;

    // One classified transaction for the back end
    typedef struct packed {
        logic                has_hdr;
        logic                has_data;
        logic                has_end;
        logic [SEQ_W-1:0]    hdr_seq;
        logic [7:0]          hdr_len;
        logic [7:0]          data_byte;
        logic                data_end;
        logic [SEQ_W-1:0]    end_seq;
        logic [FRAMES_W-1:0] frames;
        logic [CRC_W-1:0]    crc;
    } t_cmd;

    // Reflected CRC-32 over one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-8){1'b0}}, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Packet capacity in bytes: clamp((mtu-7)/FRAME_BYTES,1,MAX_FPP) frames
    function automatic logic [PKT_W-1:0] cap_of(input logic [MTU_W-1:0] mtu);
        logic [PKT_W-1:0] cap;
        cap = PKT_W'(FRAME_BYTES);
        for (int k = 2; k <= MAX_FPP; k++) begin
            if (CMP_W'(mtu) >= CMP_W'(OVERHEAD + FRAME_BYTES * k)) begin
                cap = PKT_W'(FRAME_BYTES * k);
            end
        end
        return cap;
    endfunction

endpackage

// File: rtl/burst_packet_framer_crc32_top.sv
// Burst packet framer with CRC-32. A start transaction (mode 0) opens a burst
// of frame_total frames of 12 bytes, sampling the MTU register for the packet
// size; payload transactions (mode 1) then carry one byte each and come out
// framed in data packets (4-byte header, type 0x02), followed after the last
// byte by a 12-byte end packet (type 0x03) holding the sequence number, frame
// count and the reflected CRC-32 of the payload. Input transactions are taken
// one per clock while the 4-entry command queue between the classifying front
// end and the byte serializer has room; each transaction yields 0 to 17 result
// bytes, and the serializer delivers one result byte per clock while results
// are popped. Each command passes through the command queue, the serializer's
// command register and its output register before its first result byte
// shows on the result ports. The MTU register may be written at any cycle
// over the config channel and takes effect at the next start transaction.
module burst_packet_framer_crc32_top import bpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [MTU_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_in,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_out
);

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Front end: config, classification, CRC and counters
    bpf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_accept    (accept),
        .i_item      (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Command queue
    bpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back end: byte serializer with output register
    bpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// File: rtl/bpf_front.sv
module bpf_front import bpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [MTU_W-1:0] i_cfg_data,
    output logic             o_cfg_ready,
    input  logic             i_accept,
    input  t_in_item         i_item,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd
);

    logic [MTU_W-1:0]    r_mtu;
    logic [PKT_W-1:0]    r_cap;
    logic [CRC_W-1:0]    r_crc;
    logic [SEQ_W-1:0]    r_seq;
    logic [BURST_W-1:0]  r_burst_left;
    logic [PKT_W-1:0]    r_pkt_left;
    logic [FRAMES_W-1:0] r_frames;
    logic                r_active;

    logic [BURST_W-1:0]  n_burst_total;
    logic                hdr_needed;
    logic [PKT_W-1:0]    plen;
    logic [PKT_W-1:0]    n_pkt_left;
    logic [BURST_W-1:0]  n_burst_left;
    logic [CRC_W-1:0]    n_crc;
    logic                pkt_done;
    logic                burst_done;
    logic [SEQ_W-1:0]    n_seq;

    assign o_cfg_ready = 1'b1;

    // Start transaction: byte count of the burst
    assign n_burst_total = BURST_W'(i_item.frame_total) * BURST_W'(FRAME_BYTES);

    // Payload byte: packet bookkeeping and CRC
    assign hdr_needed   = (r_pkt_left == '0);
    assign plen         = !hdr_needed ? r_pkt_left :
                          (r_burst_left < BURST_W'(r_cap)) ? PKT_W'(r_burst_left) : r_cap;
    assign n_pkt_left   = plen - PKT_W'(1);
    assign n_burst_left = r_burst_left - BURST_W'(1);
    assign n_crc        = crc_byte(r_crc, i_item.data_byte);
    assign pkt_done     = (n_pkt_left == '0);
    assign burst_done   = (n_burst_left == '0);
    assign n_seq        = r_seq + SEQ_W'(pkt_done);

    // Command toward the back end
    always_comb begin
        o_cmd       = '0;
        o_cmd_valid = 1'b0;
        if (i_item.mode == MODE_START) begin
            o_cmd_valid  = i_accept && (n_burst_total == '0);
            o_cmd.has_end = 1'b1;
            o_cmd.end_seq = '0;
            o_cmd.frames  = i_item.frame_total;
            o_cmd.crc     = '0;
        end else begin
            o_cmd_valid     = i_accept && r_active;
            o_cmd.has_hdr   = hdr_needed;
            o_cmd.has_data  = 1'b1;
            o_cmd.has_end   = burst_done;
            o_cmd.hdr_seq   = r_seq;
            o_cmd.hdr_len   = 8'(plen);
            o_cmd.data_byte = i_item.data_byte;
            o_cmd.data_end  = pkt_done;
            o_cmd.end_seq   = n_seq;
            o_cmd.frames    = r_frames;
            o_cmd.crc       = n_crc ^ CRC_INIT;
        end
    end

    // Framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu        <= MTU_RESET;
            r_cap        <= PKT_W'(FRAME_BYTES);
            r_crc        <= CRC_INIT;
            r_seq        <= '0;
            r_burst_left <= '0;
            r_pkt_left   <= '0;
            r_frames     <= '0;
            r_active     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mtu <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_item.mode == MODE_START) begin
                    r_cap        <= cap_of(r_mtu);
                    r_frames     <= i_item.frame_total;
                    r_burst_left <= n_burst_total;
                    r_pkt_left   <= '0;
                    r_crc        <= CRC_INIT;
                    r_seq        <= '0;
                    r_active     <= (n_burst_total != '0);
                end else if (r_active) begin
                    r_crc        <= n_crc;
                    r_pkt_left   <= n_pkt_left;
                    r_burst_left <= n_burst_left;
                    r_seq        <= n_seq;
                    r_active     <= !burst_done;
                end
            end
        end
    end

endmodule

// File: rtl/bpf_fifo.sv
module bpf_fifo import bpf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wptr;
    logic [Q_AW-1:0] r_rptr;
    logic [Q_CW-1:0] r_count;

    logic push_en;
    logic pop_en;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_wptr <= r_wptr + Q_AW'(1);
            end
            if (pop_en) begin
                r_rptr <= r_rptr + Q_AW'(1);
            end
            r_count <= r_count + Q_CW'(push_en) - Q_CW'(pop_en);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("queue fill level beyond depth");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_en && !push_en |=> r_count == $past(r_count) - Q_CW'(1))
        else $error("queue fill level wrong after pop");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en && !pop_en |=> r_count == $past(r_count) + Q_CW'(1))
        else $error("queue fill level wrong after push");

endmodule

// File: rtl/bpf_back.sv
module bpf_back import bpf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_out
);

    t_cmd             r_cmd;
    logic             r_busy;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] n_idx;
    logic             at_last;
    logic             advance;
    logic             fetch;
    logic             pop_en;
    t_out_item        n_out;

    assign pop_en   = i_pop && r_out_valid;
    assign advance  = r_busy && (!r_out_valid || pop_en);
    assign last_idx = r_cmd.has_end ? ST_END_CRC0 : ST_DATA;
    assign at_last  = (r_idx == last_idx);
    assign fetch    = !r_busy || (advance && at_last);
    assign o_q_pop  = fetch && i_q_valid;
    assign n_idx    = (r_idx == ST_DATA) ? ST_END_TYPE : r_idx + IDX_W'(1);

    // First step of the incoming command
    always_comb begin
        priority if (i_q_cmd.has_hdr) begin
            first_idx = ST_HDR_TYPE;
        end else if (i_q_cmd.has_data) begin
            first_idx = ST_DATA;
        end else begin
            first_idx = ST_END_TYPE;
        end
    end

    // Byte select for the current step
    always_comb begin
        n_out            = '0;
        n_out.run_last   = at_last;
        unique case (r_idx)
            ST_HDR_TYPE: n_out.out_byte = TYPE_DATA;
            ST_HDR_SEQH: n_out.out_byte = r_cmd.hdr_seq[15:8];
            ST_HDR_SEQL: n_out.out_byte = r_cmd.hdr_seq[7:0];
            ST_HDR_LEN:  n_out.out_byte = r_cmd.hdr_len;
            ST_DATA: begin
                n_out.out_byte   = r_cmd.data_byte;
                n_out.packet_end = r_cmd.data_end;
            end
            ST_END_TYPE: n_out.out_byte = TYPE_END;
            ST_END_SEQH: n_out.out_byte = r_cmd.end_seq[15:8];
            ST_END_SEQL: n_out.out_byte = r_cmd.end_seq[7:0];
            ST_END_PAD:  n_out.out_byte = 8'h00;
            ST_END_CNT3: n_out.out_byte = 8'h00;
            ST_END_CNT2: n_out.out_byte = 8'h00;
            ST_END_CNT1: n_out.out_byte = r_cmd.frames[15:8];
            ST_END_CNT0: n_out.out_byte = r_cmd.frames[7:0];
            ST_END_CRC3: n_out.out_byte = r_cmd.crc[31:24];
            ST_END_CRC2: n_out.out_byte = r_cmd.crc[23:16];
            ST_END_CRC1: n_out.out_byte = r_cmd.crc[15:8];
            ST_END_CRC0: begin
                n_out.out_byte   = r_cmd.crc[7:0];
                n_out.packet_end = 1'b1;
            end
            default:     n_out.out_byte = 8'h00;
        endcase
    end

    // Command holding and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (fetch) begin
            r_busy <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= first_idx;
            end
        end else if (advance) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (pop_en) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx <= ST_END_CRC0)
        else $error("step index out of range");

    a_no_end_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_cmd.has_end |-> r_idx <= ST_DATA)
        else $error("end packet step without end packet");

    a_hdr_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_idx == ST_HDR_LEN |=> r_idx == ST_DATA)
        else $error("header not followed by payload byte");

endmodule
